@@ src/lcsr_pkg.sv @@
// Shared types and constants for the load cell serial reader.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lcsr_pkg;

   localparam int HALF_W   = 10;
   localparam int TARE_W   = 24;
   localparam int SCALE_W  = 16;
   localparam int WEIGHT_W = 24;
   localparam int DIGIT_W  = 4;
   localparam int NUM_DIGITS = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [HALF_W-1:0]   HALF_RESET  = 10'd10;
   localparam logic [TARE_W-1:0]   TARE_RESET  = 24'd8586000;
   localparam logic [SCALE_W-1:0]  SCALE_RESET = 16'd8238;
   localparam logic [WEIGHT_W-1:0] WEIGHT_CAP  = 24'd9999999;

   // x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT, exact for any 24-bit x
   localparam logic [WEIGHT_W-1:0] DIV10_MUL   = 24'hCCCCCD;
   localparam int                  DIV10_SHIFT = 27;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_PERIOD = 2'd0,
      CSR_TARE        = 2'd1,
      CSR_SCALE       = 2'd2
   } csr_index_type;

   // sideband that travels with every word down the pipeline
   typedef struct packed {
      logic live;   // stage holds a word
      logic sck;    // serial clock level after this tick
      logic done;   // this tick completed a conversion
   } lane_type;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef digit_type [NUM_DIGITS-1:0] digits_type;

endpackage

@@ src/load_cell_serial_reader_unit.sv @@
// Load cell serial reader: top level with config registers and output stage.
// Depends on lcsr_pkg, lcsr_ctrl, lcsr_scale and lcsr_digits.
//
// req_* carries one timer tick per word: the sampled converter data line.
// rsp_* returns one word per tick: the serial clock level to drive, a flag
// (rsp_tuser) set on the tick a conversion completes, and the held weight in
// hundredths of a gram with its seven BCD digits.
// csr_* writes half period (0), tare offset (1) and scale factor (2); write
// only while no ticks are in flight.
// A tick's result word shows on rsp_tvalid after passing the sequencer output
// register, three scaling stages, six divide-by-ten stages and the output
// register.
// Throughput is one tick per cycle while rsp_tready does not stall the output.
// All stages move together: when rsp_tready is low with a word waiting,
// req_tready drops and the whole pipeline holds.
// Reset clears the sequencer to idle, the held weight to zero and the config
// registers to their defaults; rsp_tvalid is low until the first tick drains.
`timescale 1ns / 1ps

module load_cell_serial_reader_unit #(
   parameter int RAW_BITS            = 24,
   parameter int SCALE_FRACTION_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: [0] data_line
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,
   // rsp_tdata: [0] sck_level, [24:1] weight_hundredths, [28:25] digit_pos6,
   // [32:29] digit_pos5, [36:33] digit_pos4, [40:37] digit_pos3,
   // [44:41] digit_pos2, [48:45] digit_pos1, [52:49] digit_pos0
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [55:0]                        rsp_tdata,
   // rsp_tuser: [0] result_valid
   output logic                               rsp_tuser,
   input  logic                               csr_wr_en,
   input  logic [lcsr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lcsr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lcsr_pkg::*;

   logic [HALF_W-1:0]   half_ff;
   logic [TARE_W-1:0]   tare_ff;
   logic [SCALE_W-1:0]  scale_ff;

   logic                out_valid_ff;
   logic                out_sck_ff;
   logic                out_done_ff;
   logic [WEIGHT_W-1:0] held_weight_ff;
   digits_type          held_digits_ff;

   logic advance, accept;
   lane_type            lane_ctrl, lane_scale, lane_dig;
   logic [RAW_BITS-1:0] raw_word;
   logic [WEIGHT_W-1:0] weight_scale, weight_dig;
   digits_type          digits_dig;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff  <= HALF_RESET;
         tare_ff  <= TARE_RESET;
         scale_ff <= SCALE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HALF_PERIOD: half_ff  <= csr_wdata[HALF_W-1:0];
            CSR_TARE:        tare_ff  <= csr_wdata[TARE_W-1:0];
            CSR_SCALE:       scale_ff <= csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   lcsr_ctrl #(
      .RAW_BITS (RAW_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .accept      (accept),
      .data_line   (req_tdata[0]),
      .half_period (half_ff),
      .lane        (lane_ctrl),
      .raw_word    (raw_word)
   );

   lcsr_scale #(
      .RAW_BITS            (RAW_BITS),
      .SCALE_FRACTION_BITS (SCALE_FRACTION_BITS)
   ) u_scale (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .lane_in      (lane_ctrl),
      .raw_word     (raw_word),
      .tare_offset  (tare_ff),
      .scale_factor (scale_ff),
      .lane_out     (lane_scale),
      .weight       (weight_scale)
   );

   lcsr_digits u_digits (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .lane_in    (lane_scale),
      .weight_in  (weight_scale),
      .lane_out   (lane_dig),
      .weight_out (weight_dig),
      .digits_out (digits_dig)
   );

   // held value only changes together with the word that completed it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         out_sck_ff     <= 1'b0;
         out_done_ff    <= 1'b0;
         held_weight_ff <= '0;
         held_digits_ff <= '0;
      end else if (advance) begin
         out_valid_ff <= lane_dig.live;
         out_sck_ff   <= lane_dig.sck;
         out_done_ff  <= lane_dig.done;
         if (lane_dig.live && lane_dig.done) begin
            held_weight_ff <= weight_dig;
            held_digits_ff <= digits_dig;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_done_ff;
   assign rsp_tdata  = {3'b000,
                        held_digits_ff[0], held_digits_ff[1], held_digits_ff[2],
                        held_digits_ff[3], held_digits_ff[4], held_digits_ff[5],
                        held_digits_ff[6], held_weight_ff, out_sck_ff};

`ifndef ASSERT_OFF
   // completion happens on a falling serial clock
   a_done_sck_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[0])
      else $error("conversion completed with serial clock high");

   // a waiting result must hold the input side
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while output stalled");

   a_weight_capped: assert property (@(posedge clock) disable iff (reset)
      held_weight_ff <= WEIGHT_CAP)
      else $error("held weight above cap");

   a_weight_changes_on_done: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(held_weight_ff) |-> rsp_tvalid && rsp_tuser)
      else $error("held weight changed without a completion word");

   a_digits_bcd: assert property (@(posedge clock) disable iff (reset)
      held_digits_ff[0] <= 4'd9 && held_digits_ff[1] <= 4'd9 &&
      held_digits_ff[2] <= 4'd9 && held_digits_ff[3] <= 4'd9 &&
      held_digits_ff[4] <= 4'd9 && held_digits_ff[5] <= 4'd9 &&
      held_digits_ff[6] <= 4'd9)
      else $error("held digit out of BCD range");
`endif

endmodule

@@ src/lcsr_ctrl.sv @@
// Serial clock sequencer: tick counting, pulse count and MSB-first sampling.
// Depends on lcsr_pkg.
`timescale 1ns / 1ps

module lcsr_ctrl #(
   parameter int RAW_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          accept,
   input  logic                          data_line,
   input  logic [lcsr_pkg::HALF_W-1:0]   half_period,
   output lcsr_pkg::lane_type            lane,
   output logic [RAW_BITS-1:0]           raw_word
);
   import lcsr_pkg::*;

   localparam int PULSE_W = $clog2(RAW_BITS + 2);

   logic [PULSE_W-1:0]  pulse_ff,  pulse_in;
   logic                high_ff,   high_in;
   logic [HALF_W-1:0]   tick_ff,   tick_in;
   logic [RAW_BITS-1:0] shift_ff,  shift_in;
   logic                done_in;
   lane_type            lane_ff;
   logic [RAW_BITS-1:0] word_ff;

   logic [HALF_W-1:0] half;
   logic [HALF_W-1:0] tick_next;

   // a zero half period behaves as one tick
   assign half      = (half_period == '0) ? HALF_W'(1) : half_period;
   assign tick_next = tick_ff + HALF_W'(1);

   always_comb begin
      pulse_in = pulse_ff;
      high_in  = high_ff;
      tick_in  = tick_ff;
      shift_in = shift_ff;
      done_in  = 1'b0;
      if (pulse_ff == '0) begin
         if (!data_line) begin
            pulse_in = PULSE_W'(1);
            high_in  = 1'b1;
            tick_in  = '0;
            shift_in = '0;
         end
      end else if (tick_next >= half) begin
         tick_in = '0;
         if (high_ff) begin
            high_in = 1'b0;
            if (pulse_ff <= PULSE_W'(RAW_BITS)) begin
               shift_in = {shift_ff[RAW_BITS-2:0], data_line};
            end else begin
               done_in  = 1'b1;
               pulse_in = '0;
            end
         end else begin
            pulse_in = pulse_ff + PULSE_W'(1);
            high_in  = 1'b1;
         end
      end else begin
         tick_in = tick_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff <= '0;
         high_ff  <= 1'b0;
         tick_ff  <= '0;
         shift_ff <= '0;
      end else if (accept) begin
         pulse_ff <= pulse_in;
         high_ff  <= high_in;
         tick_ff  <= tick_in;
         shift_ff <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else if (advance) begin
         lane_ff.live <= accept;
         lane_ff.sck  <= high_in;
         lane_ff.done <= accept && done_in;
      end
   end

   // shift register is unchanged on the completing tick
   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= shift_ff;
      end
   end

   assign lane     = lane_ff;
   assign raw_word = word_ff;

endmodule

@@ src/lcsr_scale.sv @@
// Raw word to weight: sign flip and tare, Q0.16 scaling, clamp and cap.
// Three registered stages; depends on lcsr_pkg.
`timescale 1ns / 1ps

module lcsr_scale #(
   parameter int RAW_BITS            = 24,
   parameter int SCALE_FRACTION_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  lcsr_pkg::lane_type              lane_in,
   input  logic [RAW_BITS-1:0]             raw_word,
   input  logic [lcsr_pkg::TARE_W-1:0]     tare_offset,
   input  logic [lcsr_pkg::SCALE_W-1:0]    scale_factor,
   output lcsr_pkg::lane_type              lane_out,
   output logic [lcsr_pkg::WEIGHT_W-1:0]   weight
);
   import lcsr_pkg::*;

   localparam int CW = (RAW_BITS > TARE_W) ? RAW_BITS : TARE_W;
   localparam int PW = CW + SCALE_W;

   lane_type            lane_a_ff, lane_b_ff, lane_c_ff;
   logic [CW-1:0]       diff_ff;
   logic [PW-1:0]       prod_ff;
   logic [WEIGHT_W-1:0] weight_ff;

   logic [CW-1:0] raw_ext, tare_ext, diff_in;
   logic [PW-1:0] prod_in, shifted;
   logic [WEIGHT_W-1:0] weight_in;

   // offset binary to two's complement ordering: flip the top bit
   assign raw_ext  = CW'(raw_word ^ {1'b1, {(RAW_BITS-1){1'b0}}});
   assign tare_ext = CW'(tare_offset);
   assign diff_in  = (raw_ext > tare_ext) ? (raw_ext - tare_ext) : '0;

   assign prod_in  = PW'(diff_ff) * PW'(scale_factor);

   assign shifted   = prod_ff >> SCALE_FRACTION_BITS;
   assign weight_in = (shifted > PW'(WEIGHT_CAP)) ? WEIGHT_CAP : shifted[WEIGHT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_a_ff <= '0;
         lane_b_ff <= '0;
         lane_c_ff <= '0;
      end else if (advance) begin
         lane_a_ff <= lane_in;
         lane_b_ff <= lane_a_ff;
         lane_c_ff <= lane_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff   <= diff_in;
         prod_ff   <= prod_in;
         weight_ff <= weight_in;
      end
   end

   assign lane_out = lane_c_ff;
   assign weight   = weight_ff;

endmodule

@@ src/lcsr_digits.sv @@
// Weight to seven BCD digits, one divide-by-ten per registered stage.
// Depends on lcsr_pkg.
`timescale 1ns / 1ps

module lcsr_digits (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  lcsr_pkg::lane_type              lane_in,
   input  logic [lcsr_pkg::WEIGHT_W-1:0]   weight_in,
   output lcsr_pkg::lane_type              lane_out,
   output logic [lcsr_pkg::WEIGHT_W-1:0]   weight_out,
   output lcsr_pkg::digits_type            digits_out
);
   import lcsr_pkg::*;

   localparam int NDIV = NUM_DIGITS - 1;
   localparam int MW   = 2 * WEIGHT_W;

   lane_type            lane_ff   [NDIV];
   logic [WEIGHT_W-1:0] weight_ff [NDIV];
   logic [WEIGHT_W-1:0] quot_ff   [NDIV];
   digits_type          dig_ff    [NDIV];

   for (genvar k = 0; k < NDIV; k++) begin : g_stage
      lane_type            lane_src;
      logic [WEIGHT_W-1:0] weight_src, x;
      digits_type          dig_src, dig_in;
      logic [MW-1:0]       prod;
      logic [WEIGHT_W-1:0] q, rem;

      if (k == 0) begin : g_first
         assign lane_src   = lane_in;
         assign weight_src = weight_in;
         assign x          = weight_in;
         assign dig_src    = '0;
      end else begin : g_next
         assign lane_src   = lane_ff[k-1];
         assign weight_src = weight_ff[k-1];
         assign x          = quot_ff[k-1];
         assign dig_src    = dig_ff[k-1];
      end

      assign prod = MW'(x) * MW'(DIV10_MUL);
      assign q    = WEIGHT_W'(prod >> DIV10_SHIFT);
      assign rem  = x - ((q << 3) + (q << 1));

      always_comb begin
         dig_in    = dig_src;
         dig_in[k] = rem[DIGIT_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            lane_ff[k] <= '0;
         end else if (advance) begin
            lane_ff[k] <= lane_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            weight_ff[k] <= weight_src;
            quot_ff[k]   <= q;
            dig_ff[k]    <= dig_in;
         end
      end
   end

   // what is left after six divisions is the millions digit
   always_comb begin
      digits_out             = dig_ff[NDIV-1];
      digits_out[NDIV]       = quot_ff[NDIV-1][DIGIT_W-1:0];
   end

   assign lane_out   = lane_ff[NDIV-1];
   assign weight_out = weight_ff[NDIV-1];

endmodule

@@ tb/tb_load_cell_serial_reader_unit.sv @@
// Self-checking testbench for load_cell_serial_reader_unit.
// Drives timer ticks through req_*, predicts every rsp_* word and compares them.
// Depends on lcsr_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_load_cell_serial_reader_unit;
   import lcsr_pkg::*;

   localparam int          CLK_HALF_NS  = 10;
   localparam int          RESET_CYCLES = 9;
   localparam int          DRAIN_PAUSE  = 16;
   localparam int          LONG_HOLD    = 400;
   localparam int          RANDOM_TICKS = 200;
   localparam int          CYCLE_LIMIT  = 4000000;
   localparam int          LAST_PULSE   = 25;
   localparam logic [23:0] SIGN_FLIP    = 24'h800000;

   typedef struct {
      logic                sck;
      logic                done;
      logic [WEIGHT_W-1:0] weight;
      digits_type          digits;   // digits[k] is digit_pos k
   } reader_word_t;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'd0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [55:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_HALF_PERIOD;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   load_cell_serial_reader_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // shadow registers and sequencer copy
   logic [HALF_W-1:0]   cfg_half  = HALF_RESET;
   logic [TARE_W-1:0]   cfg_tare  = TARE_RESET;
   logic [SCALE_W-1:0]  cfg_scale = SCALE_RESET;
   logic [4:0]          seq_pulse = '0;
   logic                seq_high  = 1'b0;
   logic [HALF_W-1:0]   seq_ticks = '0;
   logic [23:0]         seq_shift = '0;
   logic [WEIGHT_W-1:0] held_weight = '0;

   logic         tick_pending[$];
   reader_word_t pending_readouts[$];
   reader_word_t got_ref;

   int  burst_left = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_used = 1'b0;
   bit  hold_trigger = 1'b0;
   bit  flow_free = 1'b0;
   int  fail_count = 0;
   int  cycle_count = 0;
   int  words_checked = 0;
   int  conversions = 0;
   int  zero_results = 0;
   int  capped_results = 0;
   int  ticks_queued = 0;
   int  reads_queued = 0;
   int  settings_used = 1;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF_NS clock = ~clock;
   end

   function automatic logic [WEIGHT_W-1:0] scaled_weight(input logic [23:0] word);
      logic [23:0] raw;
      logic [39:0] prod;
      raw = word ^ SIGN_FLIP;
      if (raw <= cfg_tare)
         return '0;
      prod = ({16'd0, raw} - {16'd0, cfg_tare}) * {24'd0, cfg_scale};
      prod = prod >> 16;
      if (prod > {16'd0, WEIGHT_CAP})
         return WEIGHT_CAP;
      return prod[WEIGHT_W-1:0];
   endfunction

   // one timer tick through the serial sequencer; queues the word it yields
   task automatic advance_sequencer(input logic data_bit);
      logic [HALF_W-1:0]   span;
      logic                done;
      logic [WEIGHT_W-1:0] v;
      reader_word_t        r;
      int                  k;
      span = (cfg_half == '0) ? 10'd1 : cfg_half;
      done = 1'b0;
      if (seq_pulse == '0) begin
         if (!data_bit) begin
            seq_pulse = 5'd1;
            seq_high  = 1'b1;
            seq_ticks = '0;
            seq_shift = '0;
         end
      end else begin
         seq_ticks = seq_ticks + 1'b1;
         if (seq_ticks >= span) begin
            seq_ticks = '0;
            if (seq_high) begin
               seq_high = 1'b0;
               if (seq_pulse < LAST_PULSE) begin
                  seq_shift = {seq_shift[22:0], data_bit};
               end else begin
                  held_weight = scaled_weight(seq_shift);
                  done = 1'b1;
                  seq_pulse = '0;
               end
            end else begin
               seq_pulse = seq_pulse + 1'b1;
               seq_high  = 1'b1;
            end
         end
      end
      r.sck    = seq_high;
      r.done   = done;
      r.weight = held_weight;
      v = held_weight;
      for (k = 0; k < NUM_DIGITS; k++) begin
         r.digits[k] = DIGIT_W'(v % 24'd10);
         v = v / 24'd10;
      end
      pending_readouts.push_back(r);
   endtask

   // sender: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready)
            advance_sequencer(req_tdata[0]);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 && !flow_free) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (tick_pending.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {7'd0, tick_pending.pop_front()};
               if (burst_left > 0) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(0, 30);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: short random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
      end else if (hold_trigger && !hold_used) begin
         hold_used  <= 1'b1;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= (hold_left == 1);
      end else if (flow_free) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 7) == 0)
            stall_left <= $urandom_range(1, 12);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readouts.size() == 0) begin
            $error("result word with no tick pending: tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            got_ref = pending_readouts.pop_front();
            words_checked++;
            if (rsp_tdata[0] !== got_ref.sck) begin
               $error("sck_level: expected %0d, got %0d", got_ref.sck, rsp_tdata[0]);
               fail_count++;
            end
            if (rsp_tuser !== got_ref.done) begin
               $error("result_valid: expected %0d, got %0d", got_ref.done, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[24:1] !== got_ref.weight) begin
               $error("weight_hundredths: expected %0d, got %0d",
                      got_ref.weight, rsp_tdata[24:1]);
               fail_count++;
            end
            for (int k = 0; k < NUM_DIGITS; k++) begin
               if (rsp_tdata[25 + (6 - k) * 4 +: 4] !== got_ref.digits[k]) begin
                  $error("digit_pos%0d: expected %0d, got %0d", k, got_ref.digits[k],
                         rsp_tdata[25 + (6 - k) * 4 +: 4]);
                  fail_count++;
               end
            end
            if (got_ref.done) begin
               conversions++;
               if (got_ref.weight == '0)
                  zero_results++;
               if (got_ref.weight == WEIGHT_CAP)
                  capped_results++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("cycle limit reached with %0d words outstanding", pending_readouts.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic wait_drained();
      while (tick_pending.size() != 0 || req_tvalid || pending_readouts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_HALF_PERIOD: cfg_half  = value[HALF_W-1:0];
         CSR_TARE:        cfg_tare  = value[TARE_W-1:0];
         CSR_SCALE:       cfg_scale = value[SCALE_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic apply_setting(input logic [HALF_W-1:0] half, input logic [TARE_W-1:0] tare,
                                input logic [SCALE_W-1:0] scale);
      wait_drained();
      write_csr(CSR_HALF_PERIOD, {14'd0, half});
      write_csr(CSR_TARE, tare);
      write_csr(CSR_SCALE, {8'd0, scale});
      settings_used++;
   endtask

   task automatic queue_idle(input int n);
      repeat (n) tick_pending.push_back(1'b1);
      ticks_queued += n;
   endtask

   // a full read: start tick, then the word's bits on the falling-edge ticks,
   // noise on every other tick
   task automatic queue_read(input logic [23:0] word);
      int h;
      int t;
      int k;
      h = (cfg_half == '0) ? 1 : int'(cfg_half);
      tick_pending.push_back(1'b0);
      for (t = 1; t <= 49 * h; t++) begin
         k = (t + h) / (2 * h);
         if (t % (2 * h) == h && k < LAST_PULSE)
            tick_pending.push_back(word[24 - k]);
         else
            tick_pending.push_back(1'($urandom_range(0, 1)));
      end
      ticks_queued += 49 * h + 1;
      reads_queued++;
   endtask

   function automatic logic [23:0] word_for_raw(input logic [23:0] raw);
      return raw ^ SIGN_FLIP;
   endfunction

   initial begin
      int          phase;
      int          start_ticks;
      int          n_reads;
      logic [9:0]  half;
      logic [23:0] tare;
      logic [15:0] scale;
      logic [23:0] raw;

      reset = 1'b1;
      // defaults out of reset
      queue_idle(3);
      queue_read(word_for_raw(TARE_RESET + 24'd100000));
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // half period 0 acts as 1; zero, at and just above the tare, and the top raw value
      apply_setting(10'd0, TARE_RESET, SCALE_RESET);
      queue_read(word_for_raw(24'h000000));
      queue_read(word_for_raw(TARE_RESET));
      queue_idle(2);
      queue_read(word_for_raw(TARE_RESET + 24'd1));
      queue_read(word_for_raw(24'hFFFFFF));

      // full-scale gain: cap and just around it
      apply_setting(10'd1, 24'd0, 16'hFFFF);
      queue_read(word_for_raw(24'hFFFFFF));
      queue_read(word_for_raw(24'h000000));
      queue_read(word_for_raw(24'd1));
      queue_read(word_for_raw(24'd10000153));
      queue_read(word_for_raw(24'd10000000));

      apply_setting(10'd1, 24'd0, 16'd0);
      queue_read(word_for_raw(24'hFFFFFF));

      apply_setting(10'd2, 24'hFFFFFF, 16'hFFFF);
      queue_read(word_for_raw(24'hFFFFFF));

      // one read with no idling on either side
      apply_setting(10'd2, 24'd0, 16'd40000);
      flow_free = 1'b1;
      queue_read(24'($urandom));
      wait_drained();
      flow_free = 1'b0;

      start_ticks = ticks_queued;
      phase = 0;
      while (ticks_queued - start_ticks < RANDOM_TICKS) begin
         case ($urandom_range(0, 4))
            0:       half = 10'd0;
            1:       half = 10'd1;
            2, 3:    half = 10'($urandom_range(2, 4));
            default: half = 10'($urandom_range(5, 8));
         endcase
         case ($urandom_range(0, 3))
            0:       tare = TARE_RESET;
            1:       tare = 24'($urandom);
            2:       tare = 24'd0;
            default: tare = 24'($urandom_range(24'h7F0000, 24'h900000));
         endcase
         case ($urandom_range(0, 3))
            0:       scale = SCALE_RESET;
            1:       scale = 16'($urandom);
            2:       scale = 16'hFFFF;
            default: scale = 16'($urandom_range(1, 16));
         endcase
         apply_setting(half, tare, scale);
         flow_free = (phase % 4 == 3);
         n_reads = $urandom_range(1, 4);
         repeat (n_reads) begin
            if ($urandom_range(0, 1) == 0)
               queue_idle($urandom_range(1, 5));
            case ($urandom_range(0, 3))
               0:       raw = cfg_tare + 24'($urandom_range(0, 6)) - 24'd3;
               1:       raw = 24'($urandom_range(24'hF00000, 24'hFFFFFF));
               2:       raw = 24'($urandom_range(0, 24'h0FFFFF));
               default: raw = 24'($urandom);
            endcase
            queue_read(word_for_raw(raw));
         end
         // stall the result side long enough to back the pipeline up
         if (phase == 0)
            hold_trigger = 1'b1;
         wait_drained();
         flow_free = 1'b0;
         phase++;
      end

      wait_drained();
      repeat (DRAIN_PAUSE) @(posedge clock);
      if (pending_readouts.size() != 0) begin
         $error("%0d result words never arrived", pending_readouts.size());
         fail_count++;
      end
      $display("Run covered %0d ticks in %0d reads across %0d register settings, %0d words checked",
               ticks_queued, reads_queued, settings_used, words_checked);
      $display("Conversions: %0d total, %0d clamped to zero, %0d capped at full scale",
               conversions, zero_results, capped_results);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ load_cell_serial_reader_unit.f @@
src/lcsr_pkg.sv
src/lcsr_ctrl.sv
src/lcsr_scale.sv
src/lcsr_digits.sv
src/load_cell_serial_reader_unit.sv
tb/tb_load_cell_serial_reader_unit.sv
